@@ hw/rtl/wps_pkg.sv @@
// Shared constants, types and helper functions of the weighted permutation sampler.
// Used by the channel interfaces, the two memories and the top level; depends on nothing.
package wps_pkg;

	localparam int SLOTS       = 256;
	localparam int WEIGHT_BITS = 16;
	localparam int SLOT_W      = $clog2(SLOTS);
	localparam int CNT_W       = $clog2(SLOTS + 1);
	localparam int SUM_W       = WEIGHT_BITS + SLOT_W;
	localparam int CFG_W       = 9;
	localparam int BYTE_W      = 8;
	localparam int WIN_W       = 16;
	localparam int RND_W       = 16;
	localparam int CMP_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int SLOT_XW     = SLOT_W + BYTE_W;
	localparam int WEIGHT_XW   = WEIGHT_BITS + WIN_W;
	localparam int PROD_W      = RND_W + SUM_W;
	localparam logic [CFG_W-1:0] ITEMS_RESET = CFG_W'(256);

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_DRAW = 1'b1
	} wps_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_MUL,
		ST_WALK,
		ST_FETCH,
		ST_SWAP,
		ST_EMIT
	} wps_state_t;

	// Reports a count or an index modulo 256.
	function automatic logic [BYTE_W-1:0] to_byte(input logic [CNT_W-1:0] v);
		logic [BYTE_W+CNT_W-1:0] t;
		t = {{BYTE_W{1'b0}}, v};
		return t[BYTE_W-1:0];
	endfunction

	// Keeps the low WEIGHT_BITS bits of a loaded weight.
	function automatic logic [WEIGHT_BITS-1:0] fit_weight(input logic [WIN_W-1:0] v);
		logic [WEIGHT_XW-1:0] t;
		t = {{WEIGHT_BITS{1'b0}}, v};
		return t[WEIGHT_BITS-1:0];
	endfunction

endpackage

@@ hw/rtl/wps_intf.sv @@
// Valid/ready channel interfaces for request words and result words.
// Depends on wps_pkg for the field widths.
interface wps_req_if;
	import wps_pkg::*;
	logic              valid;
	logic              ready;
	logic              operation;
	logic [BYTE_W-1:0] slot;
	logic [WIN_W-1:0]  weight;
	logic [RND_W-1:0]  random;
	modport source (output valid, operation, slot, weight, random, input ready);
	modport sink   (input valid, operation, slot, weight, random, output ready);
endinterface

interface wps_res_if;
	import wps_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] item;
	logic [BYTE_W-1:0] position;
	logic              last;
	modport source (output valid, item, position, last, input ready);
	modport sink   (input valid, item, position, last, output ready);
endinterface

@@ hw/rtl/wps_wmem.sv @@
// Weight store: one write port, one registered read port, per-entry valid bits.
// An entry never written reads as weight one. Depends on wps_pkg.
module wps_wmem (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            we,
	input  logic [wps_pkg::SLOT_W-1:0]      waddr,
	input  logic [wps_pkg::WEIGHT_BITS-1:0] wdata,
	input  logic [wps_pkg::SLOT_W-1:0]      raddr,
	output logic [wps_pkg::WEIGHT_BITS-1:0] rdata
);
	import wps_pkg::*;

	logic [WEIGHT_BITS-1:0] mem [SLOTS];
	logic [SLOTS-1:0]       vld_q;
	logic [WEIGHT_BITS-1:0] rdata_q;
	logic                   rvld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rvld_q <= vld_q[raddr];
		end
	end

	assign rdata = rvld_q ? rdata_q : WEIGHT_BITS'(1);

endmodule

@@ hw/rtl/wps_lmem.sv @@
// Remaining-item list: one write port, one registered read port, per-entry valid bits.
// Asserting clr clears every valid bit, which restores identity order. Depends on wps_pkg.
module wps_lmem (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       clr,
	input  logic                       we,
	input  logic [wps_pkg::SLOT_W-1:0] waddr,
	input  logic [wps_pkg::SLOT_W-1:0] wdata,
	input  logic [wps_pkg::SLOT_W-1:0] raddr,
	output logic [wps_pkg::SLOT_W-1:0] rdata
);
	import wps_pkg::*;

	logic [SLOT_W-1:0] mem [SLOTS];
	logic [SLOTS-1:0]  vld_q;
	logic [SLOT_W-1:0] rdata_q;
	logic [SLOT_W-1:0] raddr_q;
	logic              rvld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
		raddr_q <= raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (clr) begin
				vld_q <= '0;
			end else if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rvld_q <= vld_q[raddr];
		end
	end

	// An entry not written since the permutation started holds its own index.
	assign rdata = rvld_q ? rdata_q : raddr_q;

endmodule

@@ hw/rtl/weighted_permutation_sampler.sv @@
// Weighted permutation sampler: roulette-wheel draws without replacement.
// A load word is accepted whenever the sampler is idle. A draw walks the remaining list up to the
// chosen entry, and the first draw of a permutation sums the n weights before its walk.
// Both walks run one entry a cycle through the single accumulate-and-compare unit.
// Reset: weights read as one, list in identity order, no permutation open, items in use 256.
module weighted_permutation_sampler (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [wps_pkg::CFG_W-1:0] cfg_wdata,
	wps_req_if.sink                   req,
	wps_res_if.source                 res
);
	import wps_pkg::*;

	wps_state_t state_q, state_d;

	logic [CFG_W-1:0]       items_q;
	logic [CNT_W-1:0]       count_q;
	logic [SLOT_W-1:0]      pos_q;
	logic [SUM_W-1:0]       sum_q;
	logic [RND_W-1:0]       rnd_q;
	logic [SUM_W-1:0]       target_q;
	logic [SUM_W-1:0]       acc_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   sum_s1;
	logic                   walk_s1;
	logic                   walk_s2;
	logic [SLOT_W-1:0]      widx_s1;
	logic [SLOT_W-1:0]      widx_s2;
	logic [SLOT_W-1:0]      witem_s2;
	logic [SLOT_W-1:0]      ch_item_q;
	logic [SLOT_W-1:0]      ch_idx_q;
	logic [WEIGHT_BITS-1:0] ch_w_q;
	logic [SLOT_W-1:0]      res_item_q;
	logic [SLOT_W-1:0]      res_pos_q;
	logic                   res_last_q;
	logic                   out_valid_q;
	logic [BYTE_W-1:0]      out_item_q;
	logic [BYTE_W-1:0]      out_pos_q;
	logic                   out_last_q;

	logic                   accept;
	logic                   load_acc;
	logic                   draw_acc;
	logic                   sum_issue;
	logic                   sum_done;
	logic                   walk_issue;
	logic                   found;
	logic                   emit_load;
	logic                   l_clr;
	logic                   l_we;
	logic [SLOT_W-1:0]      l_raddr;
	logic [SLOT_W-1:0]      l_rdata;
	logic                   w_we;
	logic [SLOT_W-1:0]      w_raddr;
	logic [WEIGHT_BITS-1:0] w_rdata;
	logic [SUM_W-1:0]       acc_nxt;
	logic [CNT_W-1:0]       last_idx;
	logic [CNT_W-1:0]       n_start;
	logic [CMP_W-1:0]       items_w;
	logic [SLOT_XW-1:0]     slot_wide;
	logic [PROD_W-1:0]      prod;

	wps_wmem u_wmem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (w_we),
		.waddr  (slot_wide[SLOT_W-1:0]),
		.wdata  (fit_weight(req.weight)),
		.raddr  (w_raddr),
		.rdata  (w_rdata)
	);

	wps_lmem u_lmem (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (l_clr),
		.we     (l_we),
		.waddr  (ch_idx_q),
		.wdata  (l_rdata),
		.raddr  (l_raddr),
		.rdata  (l_rdata)
	);

	// Datapath helpers.
	always_comb begin
		items_w   = CMP_W'(items_q);
		if (items_w == '0) begin
			n_start = CNT_W'(1);
		end else if (items_w > CMP_W'(SLOTS)) begin
			n_start = CNT_W'(SLOTS);
		end else begin
			n_start = items_w[CNT_W-1:0];
		end
		slot_wide = SLOT_XW'(req.slot);
		last_idx  = count_q - CNT_W'(1);
		acc_nxt   = acc_q + SUM_W'(w_rdata);
		prod      = PROD_W'(rnd_q) * PROD_W'(sum_q);
		found     = (state_q == ST_WALK) && walk_s2 &&
		            ((target_q < acc_nxt) || (CNT_W'(widx_s2) == last_idx));
		sum_issue = cnt_q < count_q;
		sum_done  = !sum_issue && !sum_s1;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid && req.operation == OP_DRAW) begin
					state_d = (count_q == '0) ? ST_SUM : ST_MUL;
				end
			end
			ST_SUM: begin
				if (sum_done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:   state_d = ST_WALK;
			ST_WALK: begin
				if (found) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: state_d = ST_SWAP;
			ST_SWAP:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (!out_valid_q || res.ready) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		req.ready  = 1'b0;
		walk_issue = 1'b0;
		emit_load  = 1'b0;
		l_we       = 1'b0;
		l_raddr    = cnt_q[SLOT_W-1:0];
		w_raddr    = cnt_q[SLOT_W-1:0];
		unique case (state_q)
			ST_IDLE:  req.ready = 1'b1;
			ST_SUM:   w_raddr = cnt_q[SLOT_W-1:0];
			ST_MUL:   ;
			ST_WALK: begin
				walk_issue = sum_issue && !found;
				w_raddr    = l_rdata;
			end
			ST_FETCH: l_raddr = last_idx[SLOT_W-1:0];
			ST_SWAP:  l_we = 1'b1;
			ST_EMIT:  emit_load = !out_valid_q || res.ready;
			default:  ;
		endcase
		accept   = req.valid && req.ready;
		load_acc = accept && req.operation == OP_LOAD;
		draw_acc = accept && req.operation == OP_DRAW;
		w_we     = load_acc && (slot_wide < SLOT_XW'(SLOTS));
		l_clr    = draw_acc && (count_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			items_q     <= ITEMS_RESET;
			count_q     <= '0;
			pos_q       <= '0;
			sum_q       <= '0;
			cnt_q       <= '0;
			acc_q       <= '0;
			sum_s1      <= 1'b0;
			walk_s1     <= 1'b0;
			walk_s2     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				items_q <= cfg_wdata;
			end
			sum_s1  <= (state_q == ST_SUM) && sum_issue;
			walk_s1 <= walk_issue;
			walk_s2 <= walk_s1 && !found;

			if (load_acc) begin
				count_q <= '0;
				pos_q   <= '0;
			end
			if (l_clr) begin
				count_q <= n_start;
				pos_q   <= '0;
				cnt_q   <= '0;
				acc_q   <= '0;
			end

			if (state_q == ST_SUM) begin
				if (sum_issue) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				if (sum_s1) begin
					acc_q <= acc_nxt;
				end
				if (sum_done) begin
					sum_q <= acc_q;
				end
			end

			if (state_q == ST_MUL) begin
				cnt_q <= '0;
				acc_q <= '0;
			end

			if (walk_issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (state_q == ST_WALK && walk_s2) begin
				acc_q <= acc_nxt;
			end

			if (state_q == ST_SWAP) begin
				count_q <= last_idx;
				if (count_q == CNT_W'(1)) begin
					pos_q <= '0;
					sum_q <= '0;
				end else begin
					pos_q <= pos_q + SLOT_W'(1);
					sum_q <= (sum_q >= SUM_W'(ch_w_q)) ? sum_q - SUM_W'(ch_w_q) : '0;
				end
			end

			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (draw_acc) begin
			rnd_q <= req.random;
		end
		if (state_q == ST_MUL) begin
			target_q <= prod[PROD_W-1:RND_W];
		end
		widx_s1  <= cnt_q[SLOT_W-1:0];
		widx_s2  <= widx_s1;
		witem_s2 <= l_rdata;
		if (found) begin
			ch_item_q <= witem_s2;
			ch_idx_q  <= widx_s2;
			ch_w_q    <= w_rdata;
		end
		if (state_q == ST_SWAP) begin
			res_item_q <= ch_item_q;
			res_pos_q  <= pos_q;
			res_last_q <= (count_q == CNT_W'(1));
		end
		if (emit_load) begin
			out_item_q <= to_byte(CNT_W'(res_item_q));
			out_pos_q  <= to_byte(CNT_W'(res_pos_q));
			out_last_q <= res_last_q;
		end
	end

	assign res.valid    = out_valid_q;
	assign res.item     = out_item_q;
	assign res.position = out_pos_q;
	assign res.last     = out_last_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(SLOTS))
		else $error("remaining count exceeds the number of slots");

	a_load_abandons: assert property (@(posedge clk) disable iff (!arst_n)
		load_acc |=> (count_q == '0 && pos_q == '0))
		else $error("load did not abandon the permutation in progress");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWAP && count_q == CNT_W'(1)) |=> (pos_q == '0 && sum_q == '0))
		else $error("finished permutation left position or sum behind");

	a_target_below_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && sum_q != '0) |-> (target_q < sum_q))
		else $error("draw target not below remaining sum");

	a_walk_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && walk_s2) |-> (CNT_W'(widx_s2) < count_q))
		else $error("walk reached beyond the remaining list");

endmodule
